>>> src/mpubq_pkg.sv
`default_nettype none
package mpubq_pkg;

    localparam int KIND_W = 3;
    localparam int PORT_W = 2;
    localparam int BYTE_W = 8;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [PORT_W-1:0] port_t;
    typedef logic [BYTE_W-1:0] byte_t;

    localparam kind_t KIND_HOST_WRITE = 3'd0;
    localparam kind_t KIND_HOST_READ  = 3'd1;
    localparam kind_t KIND_TX_READY   = 3'd2;
    localparam kind_t KIND_RX_BYTE    = 3'd3;
    localparam kind_t KIND_FLUSH      = 3'd4;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // sequencing commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
    } ctrl_cmd_t;

endpackage
`default_nettype wire

>>> src/mpubq_ram.sv
`default_nettype none
module mpubq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> src/mpubq_ctrl.sv
`default_nettype none
module mpubq_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output mpubq_pkg::ctrl_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                // queue read data is out of the ram now
                cmd.capture = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RESP);

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.exec, cmd.capture}))
        else $error("more than one datapath command at once");

    a_load_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.exec)
        else $error("accepted item not executed next cycle");

    a_exec_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> cmd.capture)
        else $error("executed item not captured next cycle");

    a_capture_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (m_tvalid && !s_tready))
        else $error("captured result not offered");

endmodule
`default_nettype wire

>>> src/mpubq_dp.sv
`default_nettype none
module mpubq_dp #(
    parameter int QUEUE_DEPTH = 64,
    parameter int PORT_COUNT  = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mpubq_pkg::ctrl_cmd_t  cmd,
    input  wire mpubq_pkg::kind_t      kind,
    input  wire mpubq_pkg::port_t      port,
    input  wire mpubq_pkg::byte_t      byte_in,
    output mpubq_pkg::byte_t           byte_out,
    output logic                       byte_valid,
    output logic                       accepted,
    output logic                       rx_available,
    output logic                       tx_irq_enable
);

    localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PIW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int STORE_DEPTH = PORT_COUNT * QUEUE_DEPTH;
    localparam int AW  = $clog2(STORE_DEPTH);

    typedef logic [PW-1:0] ptr_t;
    typedef logic [AW-1:0] addr_t;

    function automatic ptr_t next_ptr(input ptr_t p);
        next_ptr = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    mpubq_pkg::kind_t kind_reg;
    mpubq_pkg::port_t port_reg;
    mpubq_pkg::byte_t byte_reg;

    ptr_t tx_wp_reg [PORT_COUNT];
    ptr_t tx_rp_reg [PORT_COUNT];
    ptr_t rx_wp_reg [PORT_COUNT];
    ptr_t rx_rp_reg [PORT_COUNT];
    logic [PORT_COUNT-1:0] irq_reg;

    logic valid_pend_reg;
    logic acc_pend_reg;
    logic rd_rx_reg;

    mpubq_pkg::byte_t byte_out_reg;
    logic byte_valid_reg;
    logic accepted_reg;
    logic rx_av_reg;
    logic irq_out_reg;

    logic [PIW-1:0] port_idx;
    logic port_ok;
    ptr_t tx_wp, tx_rp, rx_wp, rx_rp;
    logic tx_empty, tx_full, rx_empty, rx_full;
    logic tx_we, tx_re, rx_we, rx_re;
    addr_t base;
    addr_t tx_waddr, tx_raddr, rx_waddr, rx_raddr;
    mpubq_pkg::byte_t tx_rdata, rx_rdata;

    assign port_idx = PIW'(port_reg);
    assign port_ok  = (int'(port_reg) < PORT_COUNT);

    always_comb begin
        tx_wp = '0;
        tx_rp = '0;
        rx_wp = '0;
        rx_rp = '0;
        if (port_ok) begin
            tx_wp = tx_wp_reg[port_idx];
            tx_rp = tx_rp_reg[port_idx];
            rx_wp = rx_wp_reg[port_idx];
            rx_rp = rx_rp_reg[port_idx];
        end
    end

    // one slot stays free so full and empty differ
    assign tx_empty = (tx_wp == tx_rp);
    assign tx_full  = (next_ptr(tx_wp) == tx_rp);
    assign rx_empty = (rx_wp == rx_rp);
    assign rx_full  = (next_ptr(rx_wp) == rx_rp);

    assign tx_we = cmd.exec && port_ok && (kind_reg == mpubq_pkg::KIND_HOST_WRITE) && !tx_full;
    assign tx_re = cmd.exec && port_ok && (kind_reg == mpubq_pkg::KIND_TX_READY) && !tx_empty;
    assign rx_we = cmd.exec && port_ok && (kind_reg == mpubq_pkg::KIND_RX_BYTE) && !rx_full;
    assign rx_re = cmd.exec && port_ok && (kind_reg == mpubq_pkg::KIND_HOST_READ) && !rx_empty;

    assign base     = AW'(int'(port_idx) * QUEUE_DEPTH);
    assign tx_waddr = base + AW'(tx_wp);
    assign tx_raddr = base + AW'(tx_rp);
    assign rx_waddr = base + AW'(rx_wp);
    assign rx_raddr = base + AW'(rx_rp);

    mpubq_ram #(
        .WIDTH (mpubq_pkg::BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_tx_store (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (byte_reg),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    mpubq_ram #(
        .WIDTH (mpubq_pkg::BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_rx_store (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (byte_reg),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= kind;
            port_reg <= port;
            byte_reg <= byte_in;
        end
        if (cmd.exec) begin
            valid_pend_reg <= tx_re || rx_re;
            acc_pend_reg   <= tx_we || rx_we;
            rd_rx_reg      <= rx_re;
        end
        if (cmd.capture) begin
            if (valid_pend_reg) begin
                byte_out_reg <= rd_rx_reg ? rx_rdata : tx_rdata;
            end else begin
                byte_out_reg <= '0;
            end
            byte_valid_reg <= valid_pend_reg;
            accepted_reg   <= acc_pend_reg;
            // status after the pointer update of this item
            rx_av_reg      <= port_ok && !rx_empty;
            irq_out_reg    <= port_ok && irq_reg[port_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PORT_COUNT; i++) begin
                tx_wp_reg[i] <= '0;
                tx_rp_reg[i] <= '0;
                rx_wp_reg[i] <= '0;
                rx_rp_reg[i] <= '0;
            end
            irq_reg <= '0;
        end else if (cmd.exec && port_ok) begin
            if (tx_we) begin
                tx_wp_reg[port_idx] <= next_ptr(tx_wp);
                irq_reg[port_idx]   <= 1'b1;
            end
            if (tx_re) begin
                tx_rp_reg[port_idx] <= next_ptr(tx_rp);
            end
            if ((kind_reg == mpubq_pkg::KIND_TX_READY) && tx_empty) begin
                irq_reg[port_idx] <= 1'b0;
            end
            if (rx_we) begin
                rx_wp_reg[port_idx] <= next_ptr(rx_wp);
            end
            if (rx_re) begin
                rx_rp_reg[port_idx] <= next_ptr(rx_rp);
            end
            if (kind_reg == mpubq_pkg::KIND_FLUSH) begin
                tx_wp_reg[port_idx] <= '0;
                tx_rp_reg[port_idx] <= '0;
                rx_wp_reg[port_idx] <= '0;
                rx_rp_reg[port_idx] <= '0;
                irq_reg[port_idx]   <= 1'b0;
            end
        end
    end

    assign byte_out      = byte_out_reg;
    assign byte_valid    = byte_valid_reg;
    assign accepted      = accepted_reg;
    assign rx_available  = rx_av_reg;
    assign tx_irq_enable = irq_out_reg;

endmodule
`default_nettype wire

>>> src/multi_port_uart_byte_queues.sv
// sequencing: an accepted item passes through execute, fetch and offer steps; the ram's
//   registered read and the result register set these steps, and a new item is accepted
//   only after the previous result has been taken by the sink
// reset: aresetn (synchronous, active low) empties every queue and clears every
//   transmit interrupt enable; queue storage is not cleared
`default_nettype none
module multi_port_uart_byte_queues #(
    parameter int QUEUE_DEPTH = 64,
    parameter int PORT_COUNT  = 4
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mpubq_pkg::S_TDATA_W-1:0]     s_tdata,  // port[1:0], byte_in[9:2]
    input  wire logic [mpubq_pkg::KIND_W-1:0]        s_tuser,  // kind[2:0]
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [mpubq_pkg::M_TDATA_W-1:0]     m_tdata,  // byte_out[7:0], accepted[8],
                                                               // rx_available[9],
                                                               // tx_irq_enable[10]
    output logic                                     m_tuser   // byte_valid
);

    mpubq_pkg::ctrl_cmd_t cmd;
    mpubq_pkg::byte_t     byte_out;
    logic                 byte_valid;
    logic                 accepted;
    logic                 rx_available;
    logic                 tx_irq_enable;

    mpubq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mpubq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PORT_COUNT  (PORT_COUNT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .kind          (s_tuser),
        .port          (s_tdata[1:0]),
        .byte_in       (s_tdata[9:2]),
        .byte_out      (byte_out),
        .byte_valid    (byte_valid),
        .accepted      (accepted),
        .rx_available  (rx_available),
        .tx_irq_enable (tx_irq_enable)
    );

    assign m_tdata = {5'd0, tx_irq_enable, rx_available, accepted, byte_out};
    assign m_tuser = byte_valid;

endmodule
`default_nettype wire

>>> tb/multi_port_uart_byte_queues_tb.sv
`default_nettype none
module multi_port_uart_byte_queues_tb;

    localparam int PORTS       = 4;
    localparam int DEPTH       = 64;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 350;

    // kinds that the block leaves without effect
    localparam mpubq_pkg::kind_t KIND_SPARE_5 = 3'd5;
    localparam mpubq_pkg::kind_t KIND_SPARE_6 = 3'd6;
    localparam mpubq_pkg::kind_t KIND_SPARE_7 = 3'd7;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        mpubq_pkg::byte_t data;
        logic             valid;
        logic             stored;
        logic             rx_nonempty;
        logic             tx_irq;
    } queue_result_t;

    typedef struct packed {
        mpubq_pkg::kind_t kind;
        mpubq_pkg::port_t port;
        mpubq_pkg::byte_t data;
        logic             typed;
        queue_result_t    want;
    } stim_row_t;

    localparam queue_result_t ALL_CLEAR = '0;
    localparam int N_DIRECTED = 24;

    // want is only used where typed is set
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{mpubq_pkg::KIND_HOST_READ,  2'd0, 8'h00, 1'b1, ALL_CLEAR},
        '{mpubq_pkg::KIND_TX_READY,   2'd1, 8'h00, 1'b1, ALL_CLEAR},
        '{mpubq_pkg::KIND_HOST_WRITE, 2'd3, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{mpubq_pkg::KIND_HOST_WRITE, 2'd3, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{mpubq_pkg::KIND_TX_READY,   2'd3, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{mpubq_pkg::KIND_TX_READY,   2'd3, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{mpubq_pkg::KIND_TX_READY,   2'd3, 8'h00, 1'b1, ALL_CLEAR},
        '{mpubq_pkg::KIND_RX_BYTE,    2'd2, 8'hA5, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{mpubq_pkg::KIND_RX_BYTE,    2'd2, 8'h5A, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{mpubq_pkg::KIND_HOST_READ,  2'd2, 8'h00, 1'b1, '{8'hA5, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{KIND_SPARE_5,               2'd2, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{KIND_SPARE_7,               2'd2, 8'h81, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{mpubq_pkg::KIND_HOST_READ,  2'd2, 8'h00, 1'b1, '{8'h5A, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{KIND_SPARE_6,               2'd1, 8'h7E, 1'b1, ALL_CLEAR},
        '{mpubq_pkg::KIND_HOST_WRITE, 2'd0, 8'h3C, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{mpubq_pkg::KIND_RX_BYTE,    2'd0, 8'hC3, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{mpubq_pkg::KIND_FLUSH,      2'd0, 8'hFF, 1'b1, ALL_CLEAR},
        '{mpubq_pkg::KIND_HOST_READ,  2'd0, 8'h00, 1'b1, ALL_CLEAR},
        '{mpubq_pkg::KIND_TX_READY,   2'd0, 8'h00, 1'b1, ALL_CLEAR},
        '{mpubq_pkg::KIND_HOST_WRITE, 2'd1, 8'h80, 1'b0, ALL_CLEAR},
        '{mpubq_pkg::KIND_RX_BYTE,    2'd1, 8'h01, 1'b0, ALL_CLEAR},
        '{mpubq_pkg::KIND_FLUSH,      2'd1, 8'h00, 1'b0, ALL_CLEAR},
        '{mpubq_pkg::KIND_HOST_WRITE, 2'd2, 8'hFE, 1'b0, ALL_CLEAR},
        '{mpubq_pkg::KIND_TX_READY,   2'd2, 8'h00, 1'b0, ALL_CLEAR}
    };

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mpubq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [mpubq_pkg::KIND_W-1:0]    s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [mpubq_pkg::M_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;

    // shadow copy of the queues
    mpubq_pkg::byte_t tx_ring [PORTS][DEPTH];
    mpubq_pkg::byte_t rx_ring [PORTS][DEPTH];
    slot_t tx_wr [PORTS];
    slot_t tx_rd [PORTS];
    slot_t rx_wr [PORTS];
    slot_t rx_rd [PORTS];
    logic  tx_irq [PORTS];

    queue_result_t pending_results[$];
    int fail_count     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int sink_stall_pct = 0;

    multi_port_uart_byte_queues u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic queue_result_t step_byte_queues(mpubq_pkg::kind_t k,
                                                       mpubq_pkg::port_t p,
                                                       mpubq_pkg::byte_t b);
        queue_result_t r;
        r = '0;
        case (k)
            mpubq_pkg::KIND_HOST_WRITE: begin
                if (slot_t'(tx_wr[p] + 1'b1) != tx_rd[p]) begin
                    tx_ring[p][tx_wr[p]] = b;
                    tx_wr[p] = tx_wr[p] + 1'b1;
                    tx_irq[p] = 1'b1;
                    r.stored = 1'b1;
                end
            end
            mpubq_pkg::KIND_HOST_READ: begin
                if (rx_wr[p] != rx_rd[p]) begin
                    r.data = rx_ring[p][rx_rd[p]];
                    r.valid = 1'b1;
                    rx_rd[p] = rx_rd[p] + 1'b1;
                end
            end
            mpubq_pkg::KIND_TX_READY: begin
                if (tx_wr[p] != tx_rd[p]) begin
                    r.data = tx_ring[p][tx_rd[p]];
                    r.valid = 1'b1;
                    tx_rd[p] = tx_rd[p] + 1'b1;
                end else begin
                    tx_irq[p] = 1'b0;
                end
            end
            mpubq_pkg::KIND_RX_BYTE: begin
                if (slot_t'(rx_wr[p] + 1'b1) != rx_rd[p]) begin
                    rx_ring[p][rx_wr[p]] = b;
                    rx_wr[p] = rx_wr[p] + 1'b1;
                    r.stored = 1'b1;
                end
            end
            mpubq_pkg::KIND_FLUSH: begin
                tx_wr[p] = '0;
                tx_rd[p] = '0;
                rx_wr[p] = '0;
                rx_rd[p] = '0;
                tx_irq[p] = 1'b0;
            end
            default: ;
        endcase
        r.rx_nonempty = (rx_wr[p] != rx_rd[p]);
        r.tx_irq = tx_irq[p];
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(mpubq_pkg::kind_t k, mpubq_pkg::port_t p, mpubq_pkg::byte_t b,
                             logic typed, queue_result_t want);
        queue_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {{(mpubq_pkg::S_TDATA_W - mpubq_pkg::BYTE_W - mpubq_pkg::PORT_W){1'b0}},
                     b, p};
        predicted = step_byte_queues(k, p, b);
        pending_results.push_back(typed ? want : predicted);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // bursts of one kind push queues to full and drain them past the wrap point; shorter bursts mix random kinds
    task automatic run_random(int n_items);
        int               sent;
        int               mode;
        int               len;
        mpubq_pkg::port_t p;
        mpubq_pkg::kind_t k;
        sent = 0;
        while (sent < n_items) begin
            p    = mpubq_pkg::port_t'($urandom_range(0, PORTS - 1));
            mode = $urandom_range(0, 9);
            len  = (mode <= 5) ? $urandom_range(1, 70) :
                   (mode <= 8) ? $urandom_range(1, 20) : $urandom_range(1, 4);
            repeat (len) begin
                case (mode)
                    0, 1: k = mpubq_pkg::KIND_HOST_WRITE;
                    2, 3: k = mpubq_pkg::KIND_RX_BYTE;
                    4:    k = mpubq_pkg::KIND_TX_READY;
                    5:    k = mpubq_pkg::KIND_HOST_READ;
                    6, 7, 8: k = mpubq_pkg::kind_t'($urandom_range(0, 3));
                    default: k = mpubq_pkg::kind_t'($urandom_range(mpubq_pkg::KIND_FLUSH,
                                                                   KIND_SPARE_7));
                endcase
                send_item(k, p, mpubq_pkg::byte_t'($urandom_range(0, 255)), 1'b0, ALL_CLEAR);
                if (k <= mpubq_pkg::KIND_FLUSH) begin
                    sent++;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        queue_result_t got;
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[7:0], m_tuser, m_tdata[8], m_tdata[9], m_tdata[10]};
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected item: byte=%02h valid=%b acc=%b rx=%b irq=%b",
                             got.data, got.valid, got.stored, got.rx_nonempty, got.tx_irq));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    note_failure($sformatf({"mismatch: expected byte=%02h valid=%b acc=%b ",
                                 "rx=%b irq=%b, got byte=%02h valid=%b acc=%b rx=%b irq=%b"},
                                 want.data, want.valid, want.stored, want.rx_nonempty,
                                 want.tx_irq, got.data, got.valid, got.stored,
                                 got.rx_nonempty, got.tx_irq));
                end
            end
        end
    end

    initial begin
        int phase;
        foreach (tx_wr[i]) begin
            tx_wr[i] = '0;
            tx_rd[i] = '0;
            rx_wr[i] = '0;
            rx_rd[i] = '0;
            tx_irq[i] = 1'b0;
        end
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DIRECTED[i]) begin
            send_item(DIRECTED[i].kind, DIRECTED[i].port, DIRECTED[i].data,
                      DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (phase = 0; phase < 4; phase++) begin
            // hold off until every result of the previous phase is back
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(negedge aclk);
            @(negedge aclk);
            case (phase)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 58; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 58; end
                default: begin send_idle_pct = 26; sink_stall_pct = 26; end
            endcase
            run_random(PHASE_ITEMS);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
